// ===== hw/rtl/pls_pkg.sv =====
`default_nettype none

package pls_pkg;

  // Store geometry
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned POS_W       = 5;
  localparam int unsigned CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_TAKE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    action_e           action;
    logic [POS_W-1:0]  position;
    logic [31:0]       value;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [31:0]       read_value;
    logic [4:0]        count;
  } out_item_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic                   ins;
    logic                   del;
    logic [IDX_W-1:0]       idx;
    logic [VALUE_WIDTH-1:0] wdata;
  } cell_cmd_t;

  // Per-item outcome from the control unit
  typedef struct packed {
    status_e           status;
    logic              do_read;
    logic [CNT_W-1:0]  count;
  } ctrl_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pls_cell.sv =====
`default_nettype none

module pls_cell (
  input  wire                             clk_i,
  input  wire pls_pkg::cell_cmd_t         cmd_i,
  input  wire [pls_pkg::IDX_W-1:0]        cell_idx_i,
  input  wire [pls_pkg::VALUE_WIDTH-1:0]  left_i,
  input  wire [pls_pkg::VALUE_WIDTH-1:0]  right_i,
  output logic [pls_pkg::VALUE_WIDTH-1:0] data_o,
  output logic [pls_pkg::VALUE_WIDTH-1:0] rd_o
);

  logic [pls_pkg::VALUE_WIDTH-1:0] data_q, data_d;
  logic                            hit;

  assign hit = (cell_idx_i == cmd_i.idx);

  // Load the new value, take from the left neighbor, or from the right one
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (hit) begin
        data_d = cmd_i.wdata;
      end else if (cell_idx_i > cmd_i.idx) begin
        data_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (cell_idx_i >= cmd_i.idx) begin
        data_d = right_i;
      end
    end
  end

  // Entry payload: no reset, contents are defined once written
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Drive the read bus only from the addressed cell
  assign rd_o   = hit ? data_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/pls_ctrl.sv =====
`default_nettype none

module pls_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      fire_i,
  input  wire pls_pkg::in_item_t   item_i,
  output pls_pkg::cell_cmd_t       cmd_o,
  output pls_pkg::ctrl_res_t       res_o
);

  logic [pls_pkg::CNT_W-1:0] count_q, count_d;
  logic [pls_pkg::CMP_W-1:0] pos_x, cnt_x;
  logic                      pos_zero;
  logic                      is_full;
  pls_pkg::status_e          status;
  logic                      ins, del, rd;

  assign pos_x    = pls_pkg::CMP_W'(item_i.position);
  assign cnt_x    = pls_pkg::CMP_W'(count_q);
  assign pos_zero = (item_i.position == '0);
  assign is_full  = (count_q == pls_pkg::CNT_W'(pls_pkg::DEPTH));

  // Check the position against the current length and decode the action
  always_comb begin
    status = pls_pkg::ST_OK;
    ins    = 1'b0;
    del    = 1'b0;
    rd     = 1'b0;
    unique case (item_i.action)
      pls_pkg::ACT_INSERT: begin
        if (pos_zero || (pos_x > cnt_x + pls_pkg::CMP_W'(1))) begin
          status = pls_pkg::ST_RANGE;
        end else if (is_full) begin
          status = pls_pkg::ST_FULL;
        end else begin
          ins = 1'b1;
        end
      end
      pls_pkg::ACT_REMOVE, pls_pkg::ACT_READ, pls_pkg::ACT_TAKE: begin
        if (pos_zero || (pos_x > cnt_x)) begin
          status = pls_pkg::ST_RANGE;
        end else begin
          rd  = (item_i.action != pls_pkg::ACT_REMOVE);
          del = (item_i.action != pls_pkg::ACT_READ);
        end
      end
      default: status = pls_pkg::ST_RANGE;
    endcase
  end

  // Advance the length on a successful insert or removal
  always_comb begin
    count_d = count_q;
    if (fire_i && ins) begin
      count_d = count_q + pls_pkg::CNT_W'(1);
    end else if (fire_i && del) begin
      count_d = count_q - pls_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign cmd_o.ins   = fire_i && ins;
  assign cmd_o.del   = fire_i && del;
  assign cmd_o.idx   = pls_pkg::IDX_W'(item_i.position - pls_pkg::POS_W'(1));
  assign cmd_o.wdata = pls_pkg::VALUE_WIDTH'(item_i.value);

  assign res_o.status  = status;
  assign res_o.do_read = rd;
  assign res_o.count   = count_d;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_store.sv =====
// Latency: a result is valid in the cycle after its item is transferred.
// Throughput: one item per cycle while the output is not stalled; each
// cell shifts and the length register is updated on the same edge.
// Reset: clears the length and the output valid; entry cells keep
// whatever they hold and are only read once written.
`default_nettype none

module positional_list_store (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire pls_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output pls_pkg::out_item_t      out_item_o
);

  localparam int unsigned N = pls_pkg::DEPTH;
  localparam int unsigned W = pls_pkg::VALUE_WIDTH;

  logic                 fire;
  pls_pkg::cell_cmd_t   cmd;
  pls_pkg::ctrl_res_t   res;
  logic [W-1:0]         cell_data [N];
  logic [W-1:0]         cell_rd   [N];
  logic [W-1:0]         rd_bus;
  logic                 out_valid_q, out_valid_d;
  pls_pkg::out_item_t   out_item_q, out_item_d;

  // Hold the input while the output register is full and stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;

  pls_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_i),
    .cmd_o  (cmd),
    .res_o  (res)
  );

  // Row of entry cells, each linked to its neighbors; the end inputs are tied to zero
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    pls_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .cell_idx_i (pls_pkg::IDX_W'(i)),
      .left_i     (left_d),
      .right_i    (right_d),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // Collect the addressed entry from the read bus
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < N; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Build the result for the transfer
  always_comb begin
    out_item_d.status     = res.status;
    out_item_d.read_value = res.do_read ? 32'(rd_bus) : 32'd0;
    out_item_d.count      = 5'(res.count);
  end

  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A transferred item shows up as a valid result in the next cycle
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("transfer did not produce a result");

  // The reported length never exceeds the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.count <= 5'(N)))
    else $error("length beyond capacity");

  // A refused item reads as zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status != pls_pkg::ST_OK) |->
      (out_item_q.read_value == 32'd0))
    else $error("error result carries data");

  // A full refusal only happens at capacity
  a_full_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status == pls_pkg::ST_FULL) |->
      (out_item_q.count == 5'(N)))
    else $error("full status below capacity");

endmodule

`default_nettype wire
